### sv/dstd_pkg.sv
// Shared types, character codes and double constants for the decimal string parser.
// No dependencies; every other file of the block imports this package.
package dstd_pkg;

  localparam int unsigned MAX_LEN_DEF   = 4096;
  localparam int unsigned EXP_LIMIT_DEF = 2047;
  localparam int unsigned OFFSET_W      = 13;
  localparam int unsigned CH_W          = 8;
  localparam int unsigned SIG_W         = 106;
  localparam int unsigned FEXP_W        = 14;

  localparam logic [CH_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CH_W-1:0] CH_NINE  = 8'h39;
  localparam logic [CH_W-1:0] CH_DOT   = 8'h2E;
  localparam logic [CH_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CH_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CH_W-1:0] CH_E     = 8'h65;

  localparam logic [63:0] DBL_ZERO  = 64'h0000_0000_0000_0000;
  localparam logic [63:0] DBL_ONE   = 64'h3FF0_0000_0000_0000;
  localparam logic [63:0] DBL_TEN   = 64'h4024_0000_0000_0000;
  localparam logic [63:0] DBL_TENTH = 64'h3FB9_9999_9999_999A;
  localparam logic [63:0] DBL_INF   = 64'h7FF0_0000_0000_0000;
  localparam logic [63:0] DBL_NAN   = 64'h7FF8_0000_0000_0000;

  typedef enum logic [2:0] {
    PH_DONE, PH_START, PH_INT_FIRST, PH_INT, PH_FRAC, PH_EXP_START, PH_EXP_FIRST, PH_EXP_DIG
  } phase_e;

  typedef enum logic [3:0] {
    ACT_NONE, ACT_NEG, ACT_SIGN, ACT_INT, ACT_DOT, ACT_E, ACT_FRAC,
    ACT_EXPNEG, ACT_EXPSIGN, ACT_EXPD, ACT_FIN, ACT_FIN_EXP
  } action_e;

  typedef enum logic [3:0] {
    ST_IDLE, ST_DECODE, ST_INT_MUL, ST_INT_ADD, ST_FRAC_SCALE, ST_FRAC_MUL,
    ST_FRAC_ADD, ST_EXP_MUL, ST_EMIT
  } ctrl_state_e;

  typedef enum logic [1:0] {F_IDLE, F_MUL, F_NORM, F_ROUND} fpu_state_e;
  typedef enum logic {FOP_MUL, FOP_ADD} fpu_op_e;
  typedef enum logic [1:0] {OPA_ACC, OPA_SCALE, OPA_TMP} opa_e;
  typedef enum logic [2:0] {OPB_TEN, OPB_TENTH, OPB_DIGIT, OPB_TMP, OPB_EXPF} opb_e;
  typedef enum logic [1:0] {DST_ACC, DST_SCALE, DST_TMP} dst_e;

  typedef struct packed {
    logic    capture;
    logic    clear;
    logic    take;
    logic    set_neg;
    logic    set_exp_neg;
    logic    exp_digit;
    logic    load_loop;
    logic    apply_exp;
    logic    dec_loop;
    logic    emit;
    logic    fpu_start;
    fpu_op_e fpu_op;
    opa_e    opa;
    opb_e    opb;
    dst_e    dst;
  } ctrl_cmd_t;

  typedef struct packed {
    logic is_digit;
    logic is_minus;
    logic is_plus;
    logic is_dot;
    logic is_e;
    logic loop_zero;
    logic out_busy;
    logic fpu_busy;
    logic fpu_done;
  } dp_status_t;

  typedef struct packed {
    logic       start;
    fpu_op_e    op;
    logic [63:0] a;
    logic [63:0] b;
  } fpu_req_t;

  function automatic logic [63:0] digit_to_double(input logic [3:0] d);
    logic [63:0] r;
    case (d)
      4'd1:    r = 64'h3FF0_0000_0000_0000;
      4'd2:    r = 64'h4000_0000_0000_0000;
      4'd3:    r = 64'h4008_0000_0000_0000;
      4'd4:    r = 64'h4010_0000_0000_0000;
      4'd5:    r = 64'h4014_0000_0000_0000;
      4'd6:    r = 64'h4018_0000_0000_0000;
      4'd7:    r = 64'h401C_0000_0000_0000;
      4'd8:    r = 64'h4020_0000_0000_0000;
      4'd9:    r = 64'h4022_0000_0000_0000;
      default: r = DBL_ZERO;
    endcase
    return r;
  endfunction

  function automatic logic [SIG_W-1:0] shr_sticky(input logic [SIG_W-1:0] s,
                                                  input logic [6:0] amt);
    logic [SIG_W-1:0] r;
    logic             lost;
    r    = s >> amt;
    lost = |(s & ~({SIG_W{1'b1}} << amt));
    return r | SIG_W'(lost);
  endfunction

endpackage

### sv/dstd_fpu.sv
// Multi-cycle double multiply and add for non-negative operands, round to nearest even.
// Depends on dstd_pkg; the multiply takes four 27x27 partial products, one per cycle.
module dstd_fpu (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  dstd_pkg::fpu_req_t req_i,
  output logic              busy_o,
  output logic              done_o,
  output logic [63:0]       result_o
);
  import dstd_pkg::*;

  fpu_state_e               state_q, state_d;
  logic [SIG_W-1:0]         sig_q, sig_d;
  logic signed [FEXP_W-1:0] exp_q, exp_d;
  logic [52:0]              ma_q, ma_d, mb_q, mb_d;
  logic [1:0]               k_q, k_d;
  logic [63:0]              res_q, res_d;
  logic                     done_q, done_d;

  logic [10:0]              ea_f, eb_f;
  logic signed [FEXP_W-1:0] ea, eb, e_big, e_small, e_diff, e_under;
  logic [52:0]              ma, mb, m_big, m_small;
  logic                     a_inf, b_inf, a_zero, b_zero;
  logic [6:0]               align_amt, under_amt;
  logic [SIG_W-1:0]         sum;
  logic [26:0]              pa, pb;
  logic [53:0]              pp;
  logic [SIG_W-1:0]         pp_sh;
  logic [52:0]              rm;
  logic                     rg, rst_bit, rup;
  logic [53:0]              mr;
  logic [52:0]              mant;
  logic signed [FEXP_W-1:0] exp_r;

  always_comb begin
    ea_f   = req_i.a[62:52];
    eb_f   = req_i.b[62:52];
    ea     = (ea_f == 11'd0) ? FEXP_W'(1) : $signed({3'b000, ea_f});
    eb     = (eb_f == 11'd0) ? FEXP_W'(1) : $signed({3'b000, eb_f});
    ma     = {ea_f != 11'd0, req_i.a[51:0]};
    mb     = {eb_f != 11'd0, req_i.b[51:0]};
    a_inf  = (ea_f == 11'h7FF);
    b_inf  = (eb_f == 11'h7FF);
    a_zero = (req_i.a[62:0] == 63'd0);
    b_zero = (req_i.b[62:0] == 63'd0);
    if (eb > ea) begin
      e_big = eb; e_small = ea; m_big = mb; m_small = ma;
    end else begin
      e_big = ea; e_small = eb; m_big = ma; m_small = mb;
    end
    e_diff    = e_big - e_small;
    align_amt = (e_diff > FEXP_W'(127)) ? 7'd127 : e_diff[6:0];
    sum       = {1'b0, m_big, 52'd0} + shr_sticky({1'b0, m_small, 52'd0}, align_amt);

    pa = k_q[1] ? {1'b0, ma_q[52:27]} : ma_q[26:0];
    pb = k_q[0] ? {1'b0, mb_q[52:27]} : mb_q[26:0];
    pp = pa * pb;
    case (k_q)
      2'd0:    pp_sh = SIG_W'(pp);
      2'd3:    pp_sh = SIG_W'(pp) << 54;
      default: pp_sh = SIG_W'(pp) << 27;
    endcase

    e_under   = FEXP_W'(1) - exp_q;
    under_amt = (e_under > FEXP_W'(127)) ? 7'd127 : e_under[6:0];

    rm      = sig_q[SIG_W-1:SIG_W-53];
    rg      = sig_q[SIG_W-54];
    rst_bit = |sig_q[SIG_W-55:0];
    rup     = rg & (rst_bit | rm[0]);
    mr      = {1'b0, rm} + 54'(rup);
    mant    = mr[53] ? mr[53:1] : mr[52:0];
    exp_r   = exp_q + FEXP_W'(mr[53]);
  end

  always_comb begin
    state_d = state_q;
    sig_d   = sig_q;
    exp_d   = exp_q;
    ma_d    = ma_q;
    mb_d    = mb_q;
    k_d     = k_q;
    res_d   = res_q;
    done_d  = 1'b0;
    case (state_q)
      F_IDLE: begin
        if (req_i.start) begin
          if (a_inf || b_inf) begin
            res_d  = (req_i.op == FOP_MUL && (a_zero || b_zero)) ? DBL_NAN : DBL_INF;
            done_d = 1'b1;
          end else if (req_i.op == FOP_MUL) begin
            sig_d   = '0;
            exp_d   = ea + eb - FEXP_W'(1022);
            ma_d    = ma;
            mb_d    = mb;
            k_d     = 2'd0;
            state_d = F_MUL;
          end else begin
            sig_d   = sum;
            exp_d   = e_big + FEXP_W'(1);
            state_d = F_NORM;
          end
        end
      end
      F_MUL: begin
        sig_d = sig_q + pp_sh;
        k_d   = k_q + 2'd1;
        if (k_q == 2'd3) begin
          state_d = F_NORM;
        end
      end
      F_NORM: begin
        if (sig_q == '0) begin
          res_d   = DBL_ZERO;
          done_d  = 1'b1;
          state_d = F_IDLE;
        end else if (exp_q < FEXP_W'(1)) begin
          sig_d = shr_sticky(sig_q, under_amt);
          exp_d = FEXP_W'(1);
        end else if (!sig_q[SIG_W-1] && exp_q > FEXP_W'(1)) begin
          sig_d = sig_q << 1;
          exp_d = exp_q - FEXP_W'(1);
        end else begin
          state_d = F_ROUND;
        end
      end
      F_ROUND: begin
        if (mant[52] && exp_r >= FEXP_W'(2047)) begin
          res_d = DBL_INF;
        end else begin
          res_d = {1'b0, mant[52] ? exp_r[10:0] : 11'd0, mant[51:0]};
        end
        done_d  = 1'b1;
        state_d = F_IDLE;
      end
      default: state_d = F_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sig_q <= sig_d;
    exp_q <= exp_d;
    ma_q  <= ma_d;
    mb_q  <= mb_d;
    k_q   <= k_d;
    res_q <= res_d;
  end

  assign busy_o   = (state_q != F_IDLE);
  assign done_o   = done_q;
  assign result_o = res_q;

endmodule

### sv/dstd_dp.sv
// Datapath of the parser: character register, accumulators, counters and output register.
// Depends on dstd_pkg and instantiates dstd_fpu; driven by commands from dstd_ctrl.
module dstd_dp #(
  parameter int unsigned MAX_LEN   = dstd_pkg::MAX_LEN_DEF,
  parameter int unsigned EXP_LIMIT = dstd_pkg::EXP_LIMIT_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [dstd_pkg::CH_W-1:0]     ch_i,
  input  dstd_pkg::ctrl_cmd_t           cmd_i,
  output dstd_pkg::dp_status_t          status_o,
  input  logic                          out_stall_i,
  output logic                          out_valid_o,
  output logic [63:0]                   value_bits_o,
  output logic [dstd_pkg::OFFSET_W-1:0] end_offset_o
);
  import dstd_pkg::*;

  localparam int unsigned CW = $clog2(MAX_LEN + 1);
  localparam int unsigned EW = $clog2(EXP_LIMIT + 1);

  logic [CH_W-1:0]     ch_q;
  logic                neg_q, exp_neg_q;
  logic [63:0]         acc_q, scale_q, tmp_q;
  logic [EW-1:0]       exp_cnt_q, loop_q;
  logic [CW-1:0]       consumed_q;
  logic                out_valid_q;
  logic [63:0]         value_q;
  logic [OFFSET_W-1:0] offset_q;

  fpu_req_t            req;
  logic                fpu_busy, fpu_done;
  logic [63:0]         fpu_res;
  logic [EW+3:0]       exp_next;

  always_comb begin
    req.start = cmd_i.fpu_start;
    req.op    = cmd_i.fpu_op;
    case (cmd_i.opa)
      OPA_SCALE: req.a = scale_q;
      OPA_TMP:   req.a = tmp_q;
      default:   req.a = acc_q;
    endcase
    case (cmd_i.opb)
      OPB_TENTH: req.b = DBL_TENTH;
      OPB_DIGIT: req.b = digit_to_double(ch_q[3:0]);
      OPB_TMP:   req.b = tmp_q;
      OPB_EXPF:  req.b = exp_neg_q ? DBL_TENTH : DBL_TEN;
      default:   req.b = DBL_TEN;
    endcase
    exp_next = (EW+4)'(exp_cnt_q) * (EW+4)'(10) + (EW+4)'(ch_q[3:0]);
  end

  dstd_fpu u_fpu (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (req),
    .busy_o   (fpu_busy),
    .done_o   (fpu_done),
    .result_o (fpu_res)
  );

  always_comb begin
    status_o.is_digit  = (ch_q inside {[CH_ZERO:CH_NINE]});
    status_o.is_minus  = (ch_q == CH_MINUS);
    status_o.is_plus   = (ch_q == CH_PLUS);
    status_o.is_dot    = (ch_q == CH_DOT);
    status_o.is_e      = (ch_q == CH_E);
    status_o.loop_zero = (loop_q == '0);
    status_o.out_busy  = out_valid_q && out_stall_i;
    status_o.fpu_busy  = fpu_busy;
    status_o.fpu_done  = fpu_done;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      neg_q       <= 1'b0;
      exp_neg_q   <= 1'b0;
      acc_q       <= DBL_ZERO;
      scale_q     <= DBL_ONE;
      tmp_q       <= DBL_ZERO;
      exp_cnt_q   <= '0;
      consumed_q  <= '0;
      loop_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.clear) begin
        neg_q      <= 1'b0;
        exp_neg_q  <= 1'b0;
        acc_q      <= DBL_ZERO;
        scale_q    <= DBL_ONE;
        exp_cnt_q  <= '0;
        consumed_q <= '0;
      end else begin
        if (cmd_i.set_neg) begin
          neg_q <= 1'b1;
        end
        if (cmd_i.set_exp_neg) begin
          exp_neg_q <= 1'b1;
        end
        if (cmd_i.exp_digit) begin
          exp_cnt_q <= (exp_next > (EW+4)'(EXP_LIMIT)) ? EW'(EXP_LIMIT) : exp_next[EW-1:0];
        end
        if (cmd_i.take && consumed_q < CW'(MAX_LEN)) begin
          consumed_q <= consumed_q + CW'(1);
        end
        if (fpu_done) begin
          case (cmd_i.dst)
            DST_SCALE: scale_q <= fpu_res;
            DST_TMP:   tmp_q   <= fpu_res;
            default:   acc_q   <= fpu_res;
          endcase
        end
      end
      if (cmd_i.load_loop) begin
        loop_q <= cmd_i.apply_exp ? exp_cnt_q : '0;
      end else if (cmd_i.dec_loop) begin
        loop_q <= loop_q - EW'(1);
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      ch_q <= ch_i;
    end
    if (cmd_i.emit) begin
      value_q  <= {acc_q[63] ^ neg_q, acc_q[62:0]};
      offset_q <= OFFSET_W'(consumed_q);
    end
  end

  assign out_valid_o  = out_valid_q;
  assign value_bits_o = value_q;
  assign end_offset_o = offset_q;

endmodule

### sv/dstd_ctrl.sv
// Controller of the parser: grammar phase, character decode and the sequence of FPU steps.
// Depends on dstd_pkg; sends commands to dstd_dp and reads its status.
module dstd_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 starts_string_i,
  output logic                 in_stall_o,
  input  dstd_pkg::dp_status_t status_i,
  output dstd_pkg::ctrl_cmd_t  cmd_o
);
  import dstd_pkg::*;

  ctrl_state_e state_q, state_d;
  phase_e      phase_q, phase_d, phase_nx;
  logic        issued_q, issued_d;
  action_e     act;
  logic        accept;

  assign accept     = in_valid_i && (state_q == ST_IDLE);
  assign in_stall_o = (state_q != ST_IDLE);

  always_comb begin
    act      = ACT_NONE;
    phase_nx = phase_q;
    case (phase_q)
      PH_START: begin
        if (status_i.is_minus) act = ACT_NEG;
        else if (status_i.is_plus) act = ACT_SIGN;
        else if (status_i.is_digit) act = ACT_INT;
        else act = ACT_FIN;
      end
      PH_INT_FIRST: act = status_i.is_digit ? ACT_INT : ACT_FIN;
      PH_INT: begin
        if (status_i.is_digit) act = ACT_INT;
        else if (status_i.is_dot) act = ACT_DOT;
        else if (status_i.is_e) act = ACT_E;
        else act = ACT_FIN;
      end
      PH_FRAC: begin
        if (status_i.is_digit) act = ACT_FRAC;
        else if (status_i.is_e) act = ACT_E;
        else act = ACT_FIN;
      end
      PH_EXP_START: begin
        if (status_i.is_minus) act = ACT_EXPNEG;
        else if (status_i.is_plus) act = ACT_EXPSIGN;
        else if (status_i.is_digit) act = ACT_EXPD;
        else act = ACT_FIN;
      end
      PH_EXP_FIRST: act = status_i.is_digit ? ACT_EXPD : ACT_FIN;
      PH_EXP_DIG:   act = status_i.is_digit ? ACT_EXPD : ACT_FIN_EXP;
      default:      act = ACT_NONE;
    endcase
    case (act)
      ACT_NEG, ACT_SIGN:       phase_nx = PH_INT_FIRST;
      ACT_INT:                 phase_nx = PH_INT;
      ACT_DOT, ACT_FRAC:       phase_nx = PH_FRAC;
      ACT_E:                   phase_nx = PH_EXP_START;
      ACT_EXPNEG, ACT_EXPSIGN: phase_nx = PH_EXP_FIRST;
      ACT_EXPD:                phase_nx = PH_EXP_DIG;
      ACT_FIN, ACT_FIN_EXP:    phase_nx = PH_DONE;
      default:                 phase_nx = phase_q;
    endcase
  end

  always_comb begin
    state_d  = state_q;
    phase_d  = phase_q;
    issued_d = issued_q;
    if (cmd_o.fpu_start) begin
      issued_d = 1'b1;
    end else if (status_i.fpu_done) begin
      issued_d = 1'b0;
    end
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_DECODE;
          if (starts_string_i) begin
            phase_d = PH_START;
          end
        end
      end
      ST_DECODE: begin
        phase_d = phase_nx;
        case (act)
          ACT_INT:              state_d = ST_INT_MUL;
          ACT_FRAC:             state_d = ST_FRAC_SCALE;
          ACT_FIN, ACT_FIN_EXP: state_d = ST_EXP_MUL;
          default:              state_d = ST_IDLE;
        endcase
      end
      ST_INT_MUL:    if (status_i.fpu_done) state_d = ST_INT_ADD;
      ST_INT_ADD:    if (status_i.fpu_done) state_d = ST_IDLE;
      ST_FRAC_SCALE: if (status_i.fpu_done) state_d = ST_FRAC_MUL;
      ST_FRAC_MUL:   if (status_i.fpu_done) state_d = ST_FRAC_ADD;
      ST_FRAC_ADD:   if (status_i.fpu_done) state_d = ST_IDLE;
      ST_EXP_MUL:    if (status_i.loop_zero && !issued_q) state_d = ST_EMIT;
      ST_EMIT:       if (!status_i.out_busy) state_d = ST_IDLE;
      default:       state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o           = '0;
    cmd_o.fpu_op    = FOP_MUL;
    cmd_o.opa       = OPA_ACC;
    cmd_o.opb       = OPB_TEN;
    cmd_o.dst       = DST_ACC;
    case (state_q)
      ST_IDLE: begin
        cmd_o.capture = accept;
        cmd_o.clear   = accept && starts_string_i;
      end
      ST_DECODE: begin
        cmd_o.take = !(act == ACT_NONE || act == ACT_FIN || act == ACT_FIN_EXP);
        cmd_o.set_neg     = (act == ACT_NEG);
        cmd_o.set_exp_neg = (act == ACT_EXPNEG);
        cmd_o.exp_digit   = (act == ACT_EXPD);
        cmd_o.load_loop   = (act == ACT_FIN || act == ACT_FIN_EXP);
        cmd_o.apply_exp   = (act == ACT_FIN_EXP);
      end
      ST_INT_MUL: begin
        cmd_o.fpu_start = !issued_q;
        cmd_o.dst       = DST_TMP;
      end
      ST_INT_ADD: begin
        cmd_o.fpu_start = !issued_q;
        cmd_o.fpu_op    = FOP_ADD;
        cmd_o.opa       = OPA_TMP;
        cmd_o.opb       = OPB_DIGIT;
      end
      ST_FRAC_SCALE: begin
        cmd_o.fpu_start = !issued_q;
        cmd_o.opa       = OPA_SCALE;
        cmd_o.opb       = OPB_TENTH;
        cmd_o.dst       = DST_SCALE;
      end
      ST_FRAC_MUL: begin
        cmd_o.fpu_start = !issued_q;
        cmd_o.opa       = OPA_SCALE;
        cmd_o.opb       = OPB_DIGIT;
        cmd_o.dst       = DST_TMP;
      end
      ST_FRAC_ADD: begin
        cmd_o.fpu_start = !issued_q;
        cmd_o.fpu_op    = FOP_ADD;
        cmd_o.opb       = OPB_TMP;
      end
      ST_EXP_MUL: begin
        cmd_o.fpu_start = !issued_q && !status_i.loop_zero;
        cmd_o.opb       = OPB_EXPF;
        cmd_o.dec_loop  = status_i.fpu_done;
      end
      ST_EMIT: cmd_o.emit = !status_i.out_busy;
      default: cmd_o.capture = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      phase_q  <= PH_DONE;
      issued_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      phase_q  <= phase_d;
      issued_q <= issued_d;
    end
  end

endmodule

### sv/decimal_string_to_double.sv
// Top level of the streaming decimal string to IEEE double parser.
// Depends on dstd_pkg; instantiates dstd_ctrl and dstd_dp.
//
// One character is taken per beat and the input stalls until that character is handled. A sign,
// '.', 'e', exponent digit or ignored character is handled by the decode step alone. An integer
// digit runs two operations and a fraction digit three on one shared double unit; a multiply
// there sums four partial products before it normalizes and rounds, and an add only normalizes
// and rounds. Normalizing takes more steps when a value is subnormal, and an infinite operand
// skips them. The character that ends the string runs one multiply for each power of ten in the
// exponent, then loads the output register, which waits while an earlier result is stalled.
module decimal_string_to_double #(
  parameter int unsigned MAX_LEN   = dstd_pkg::MAX_LEN_DEF,
  parameter int unsigned EXP_LIMIT = dstd_pkg::EXP_LIMIT_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [dstd_pkg::CH_W-1:0]     ch_i,
  input  logic                          starts_string_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [63:0]                   value_bits_o,
  output logic [dstd_pkg::OFFSET_W-1:0] end_offset_o
);
  import dstd_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  dstd_ctrl u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .starts_string_i (starts_string_i),
    .in_stall_o      (in_stall_o),
    .status_i        (status),
    .cmd_o           (cmd)
  );

  dstd_dp #(
    .MAX_LEN   (MAX_LEN),
    .EXP_LIMIT (EXP_LIMIT)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ch_i         (ch_i),
    .cmd_i        (cmd),
    .status_o     (status),
    .out_stall_i  (out_stall_i),
    .out_valid_o  (out_valid_o),
    .value_bits_o (value_bits_o),
    .end_offset_o (end_offset_o)
  );

  a_accept_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input not stalled after a beat was taken");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit |-> !(out_valid_o && out_stall_i))
    else $error("result emitted over a stalled output beat");

  a_idle_fpu: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_stall_o |-> !status.fpu_busy)
    else $error("input open while the double unit is busy");

  a_done_after_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status.fpu_done |-> $past(cmd.fpu_start || status.fpu_busy))
    else $error("double unit finished without a request");

endmodule
